@@ rtl/wpds_pkg.sv @@
package wpds_pkg;

   localparam int COORD_W   = 16;
   localparam int WEIGHT_W  = 16;
   localparam int WEIGHT_REGS = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int SUM_W     = 40;
   localparam int SCORE_W   = 32;
   localparam int POS_W     = 3;
   localparam int QUEUE_DEPTH = 2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE = 3'd6;

   // item handed from the front to the back through the queue
   typedef struct packed {
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
      logic [COORD_W-1:0] dz;
      logic [POS_W-1:0]   widx;
      logic               zero_w;   // node beyond the weighted range
      logic               last;
   } wpds_item_type;

endpackage

@@ rtl/wpds_front.sv @@
module wpds_front #(
   parameter int NODE_COUNT = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [6*wpds_pkg::COORD_W-1:0] in_data,
   input  logic                        in_last,
   output logic                        in_ready,
   input  logic                        q_full,
   output logic                        q_push,
   output wpds_pkg::wpds_item_type     q_item
);
   import wpds_pkg::*;

   localparam logic [POS_W-1:0] NODES = POS_W'(NODE_COUNT);

   logic [POS_W-1:0] pos_ff, pos_in;

   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      logic [COORD_W:0] m;
      d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
      m = d[COORD_W] ? (~d + (COORD_W+1)'(1)) : d;
      return m[COORD_W-1:0];
   endfunction

   assign in_ready = !q_full;
   assign q_push   = in_valid && !q_full;

   always_comb begin
      q_item.dx     = abs_diff(in_data[15:0],  in_data[63:48]);
      q_item.dy     = abs_diff(in_data[31:16], in_data[79:64]);
      q_item.dz     = abs_diff(in_data[47:32], in_data[95:80]);
      q_item.widx   = pos_ff;
      q_item.zero_w = (pos_ff >= NODES);
      q_item.last   = in_last;
   end

   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         if (in_last)
            pos_in = '0;
         else if (pos_ff < NODES)
            pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

@@ rtl/wpds_queue.sv @@
module wpds_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  wpds_pkg::wpds_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    empty,
   output wpds_pkg::wpds_item_type pop_item
);
   import wpds_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   wpds_item_type     mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push)
         mem_ff[wr_ff] <= push_item;
   end

endmodule

@@ rtl/wpds_back.sv @@
module wpds_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [wpds_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [wpds_pkg::WEIGHT_W-1:0]    csr_wdata,
   input  logic                             q_empty,
   input  wpds_pkg::wpds_item_type          q_item,
   output logic                             q_pop,
   output logic                             out_valid,
   output logic [wpds_pkg::SCORE_W-1:0]     out_data,
   input  logic                             out_ready
);
   import wpds_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD, ST_SQ, ST_ROOT, ST_WMUL, ST_ACC, ST_FIN_LO, ST_FIN_HI, ST_FIN_OUT
   } state_type;

   localparam logic [SUM_W:0] SAT_LIMIT = 41'h00_8001_0000; // 2^31 + 1.0

   state_type           state_ff, state_in;
   logic [4:0]          step_ff, step_in;
   wpds_item_type       item_ff, item_in;
   logic [33:0]         sq_ff, sq_in;
   logic [19:0]         rem_ff, rem_in;
   logic [16:0]         root_ff, root_in;
   logic [32:0]         wprod_ff, wprod_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [35:0]         plo_ff, plo_in, phi_ff, phi_in;
   logic                out_valid_ff, out_valid_in;
   logic [SCORE_W-1:0]  out_data_ff, out_data_in;
   logic [WEIGHT_W-1:0] weight_ff [WEIGHT_REGS];
   logic [WEIGHT_W-1:0] scale_ff;

   logic [COORD_W-1:0]   sq_op;
   logic [2*COORD_W-1:0] sq_prod;
   logic [19:0]          rem_sh, trial;
   logic [WEIGHT_W-1:0]  wsel;
   logic [55:0]          prod;
   logic [SUM_W:0]       rounded;

   assign q_pop     = (state_ff == ST_LOAD) && !q_empty;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      item_in      = item_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      wprod_in     = wprod_ff;
      sum_in       = sum_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_data_in  = out_data_ff;

      unique case (step_ff[1:0])
         2'd0:    sq_op = item_ff.dx;
         2'd1:    sq_op = item_ff.dy;
         default: sq_op = item_ff.dz;
      endcase
      sq_prod = sq_op * sq_op;
      rem_sh = {rem_ff[17:0], sq_ff[33:32]};
      trial  = {1'b0, root_ff, 2'b01};
      wsel   = item_ff.zero_w ? '0 : weight_ff[item_ff.widx];
      prod   = {phi_ff, 20'b0} + {20'b0, plo_ff};
      rounded = {1'b0, prod[55:16]} + {40'b0, prod[15]};

      unique case (state_ff)
         ST_LOAD: begin
            if (!q_empty) begin
               item_in  = q_item;
               sq_in    = '0;
               step_in  = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            sq_in = sq_ff + {2'b0, sq_prod};
            if (step_ff == 5'd2) begin
               step_in  = '0;
               rem_in   = '0;
               root_in  = '0;
               state_in = ST_ROOT;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ST_ROOT: begin
            // two radicand bits per step, one root bit per step
            sq_in = {sq_ff[31:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[15:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[15:0], 1'b0};
            end
            if (step_ff == 5'd16)
               state_in = ST_WMUL;
            else
               step_in = step_ff + 5'd1;
         end
         ST_WMUL: begin
            wprod_in = root_ff * wsel;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in   = sum_ff + {7'b0, wprod_ff};
            state_in = item_ff.last ? ST_FIN_LO : ST_LOAD;
         end
         ST_FIN_LO: begin
            plo_in   = sum_ff[19:0] * scale_ff;
            state_in = ST_FIN_HI;
         end
         ST_FIN_HI: begin
            phi_in   = sum_ff[39:20] * scale_ff;
            state_in = ST_FIN_OUT;
         end
         ST_FIN_OUT: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               if (rounded > SAT_LIMIT)
                  out_data_in = {1'b1, {(SCORE_W-1){1'b0}}};
               else
                  out_data_in = SCORE_W'(41'h1_0000 - rounded);
               sum_in   = '0;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         step_ff      <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < WEIGHT_REGS; i++)
            weight_ff[i] <= 16'd4096;
         scale_ff     <= 16'd4096;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            if (csr_addr < CSR_ADDR_W'(WEIGHT_REGS))
               weight_ff[csr_addr] <= csr_wdata;
            else if (csr_addr == REG_SCALE)
               scale_ff <= csr_wdata;
         end
      end
      item_ff     <= item_in;
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      wprod_ff    <= wprod_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      out_data_ff <= out_data_in;
   end

   a_out_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_FIN_OUT))
      else $error("result raised outside final state");
   a_sq_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQ |-> step_ff <= 5'd2)
      else $error("square step out of range");
   a_root_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROOT |-> step_ff <= 5'd16)
      else $error("root step out of range");

endmodule

@@ rtl/weighted_pose_distance_score.sv @@
// Weighted pose distance score.
// req_ channel: one transaction per feature node, the two 3-D points of the
//   node in signed Q8.8; req_tlast marks the final node of a pose pair.
// rsp_ channel: one transaction per pose pair, on its last node: the match
//   score 1.0 - scale * sum(weight_i * dist_i), signed Q16.16, saturated low.
// csr_ port: write-only, index 0..5 node weights, 6 global scale (Q4.12).
// The front computes the absolute coordinate differences and tags the node
// index, then pushes into a two-entry queue. The back runs one node at a
// time: a load state, the three squares on a shared multiplier, the
// restoring square root (one root bit per iteration), then the weight multiply
// and the accumulate. A last node adds the 40x16 scale product, done as two
// 20x16 halves, and the rounding. The root iteration sets the throughput.
// Reset clears the accumulator, the node position, the queue and loads all
// CSR registers with 4096 (1.0). A result waits in the output register while
// rsp_tready is low; the back holds in its final state once the next result
// is ready, then the queue fills and req_tready drops.
module weighted_pose_distance_score #(
   parameter int NODE_COUNT = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z
   input  logic [95:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // match_score
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [wpds_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [wpds_pkg::WEIGHT_W-1:0]   csr_wdata
);
   import wpds_pkg::*;

   logic          q_push, q_full, q_pop, q_empty;
   wpds_item_type push_item, pop_item;

   wpds_front #(.NODE_COUNT(NODE_COUNT)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_data  (req_tdata),
      .in_last  (req_tlast),
      .in_ready (req_tready),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (push_item)
   );

   wpds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (pop_item)
   );

   wpds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .q_empty   (q_empty),
      .q_item    (pop_item),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .out_ready (rsp_tready)
   );

endmodule
